@@ src/sll_pkg.sv @@
// Package with the shared types and constants of the linked list engine.
package sll_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 6;

    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AFTER = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_KEY   = 3'd5,
        ACT_FIND      = 3'd6,
        ACT_DUMP      = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_WALK,
        S_WR1,
        S_RESP
    } t_state;

endpackage

@@ src/sll_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sll_links.sv @@
// Link store: RAM plus per-entry valid bits so that unwritten entries read as the free chain.
module sll_links #(
    parameter int DEPTH = 32,
    parameter int IW    = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [IW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [IW-1:0]            o_rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [DEPTH-1:0] r_valid;
    logic             r_rvalid;
    logic [AW-1:0]    r_raddr;
    logic [IW-1:0]    ram_q;

    sll_ram #(
        .WIDTH(IW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_waddr(i_waddr),
        .i_wdata(i_wdata),
        .i_raddr(i_raddr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // The valid bit is sampled with the read so it matches the RAM's old data.
    always_ff @(posedge i_clk) begin
        r_rvalid <= r_valid[i_raddr];
        r_raddr  <= i_raddr;
    end

    assign o_rdata = r_rvalid ? ram_q : (IW'(r_raddr) + IW'(1));

endmodule

@@ src/singly_linked_list_engine_core.sv @@
// Top level of the linked list engine: request sequencer, node stores and result register.
// Searches, tail walks and dumps follow the links one node per cycle through the single read
// port of the node stores (a dump only while the output register can take its beat), and a
// dump gives one beat per element.
// No request is taken while one is in progress; a finished result may wait in the output
// register while the next request is accepted.
module singly_linked_list_engine_core import sll_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_action,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_key,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic                     o_found,
    output logic signed [DATA_W-1:0] o_item_value,
    output logic                     o_last,
    output logic [COUNT_W-1:0]       o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    t_state  r_state, n_state;
    t_action r_act, n_act;
    t_status r_rstat, n_rstat;
    logic    r_rfound, n_rfound;
    logic signed [DATA_W-1:0] r_value, n_value, r_key, n_key;
    logic [IW-1:0] r_head, n_head, r_free, n_free, r_nfree, n_nfree;
    logic [IW-1:0] r_n, n_n, r_p, n_p, r_q, n_q, r_wa, n_wa, r_wd, n_wd;
    logic [IW-1:0] r_count, n_count;

    logic                     r_ovalid;
    t_status                  r_status;
    logic                     r_found, r_last;
    logic signed [DATA_W-1:0] r_item;
    logic [COUNT_W-1:0]       r_ocount;

    logic [AW-1:0]            rd_addr, vaddr, laddr;
    logic                     vwe, lwe;
    logic [IW-1:0]            lwd, rd_lnk;
    logic signed [DATA_W-1:0] rd_val;
    logic                     ofree, ld, res_found, res_last, hit, tail, adv;
    t_status                  res_status;
    logic signed [DATA_W-1:0] res_item;
    t_action                  act_in;

    sll_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_values (
        .i_clk  (i_clk),
        .i_we   (vwe),
        .i_waddr(vaddr),
        .i_wdata(r_value),
        .i_raddr(rd_addr),
        .o_rdata(rd_val)
    );

    sll_links #(
        .DEPTH(CAPACITY),
        .IW   (IW)
    ) u_links (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (lwe),
        .i_waddr(laddr),
        .i_wdata(lwd),
        .i_raddr(rd_addr),
        .o_rdata(rd_lnk)
    );

    assign ofree  = !r_ovalid || !i_out_stall;
    assign hit    = (rd_val == r_key);
    assign tail   = (rd_lnk == NIL);
    assign act_in = t_action'(i_action);

    always_comb begin
        n_state = r_state;  n_act = r_act;   n_rstat = r_rstat; n_rfound = r_rfound;
        n_value = r_value;  n_key = r_key;   n_head = r_head;   n_free = r_free;
        n_nfree = r_nfree;  n_n = r_n;       n_p = r_p;         n_q = r_q;
        n_wa = r_wa;        n_wd = r_wd;     n_count = r_count;
        rd_addr = r_p[AW-1:0];
        vwe = 1'b0;  vaddr = r_n[AW-1:0];
        lwe = 1'b0;  laddr = r_p[AW-1:0];  lwd = NIL;
        ld = 1'b0;  res_status = ST_OK;  res_found = 1'b0;  res_item = '0;  res_last = 1'b1;
        adv = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act = act_in;  n_value = i_value;  n_key = i_key;
                    n_p = r_head;  n_q = NIL;  n_rstat = ST_OK;  n_rfound = 1'b0;
                    unique case (act_in)
                        ACT_INS_FRONT, ACT_INS_BACK: begin
                            if (r_free == NIL) begin
                                n_rstat = ST_FULL;  n_state = S_RESP;
                            end else begin
                                rd_addr = r_free[AW-1:0];  n_state = S_TAKE;
                            end
                        end
                        ACT_INS_AFTER: begin
                            if (r_free == NIL) begin
                                n_rstat = ST_FULL;  n_state = S_RESP;
                            end else if (r_head == NIL) begin
                                n_rstat = ST_EMPTY;  n_state = S_RESP;
                            end else begin
                                rd_addr = r_free[AW-1:0];  n_state = S_TAKE;
                            end
                        end
                        default: begin
                            if (r_head == NIL) begin
                                n_rstat = ST_EMPTY;  n_state = S_RESP;
                            end else begin
                                rd_addr = r_head[AW-1:0];  n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_TAKE: begin
                // The link read now shows the next free node.
                n_nfree = rd_lnk;  n_n = r_free;
                unique case (r_act)
                    ACT_INS_FRONT: begin
                        vwe = 1'b1;  vaddr = r_free[AW-1:0];
                        lwe = 1'b1;  laddr = r_free[AW-1:0];  lwd = r_head;
                        n_head = r_free;  n_free = rd_lnk;  n_count = r_count + IW'(1);
                        n_state = S_RESP;
                    end
                    ACT_INS_BACK: begin
                        vwe = 1'b1;  vaddr = r_free[AW-1:0];
                        lwe = 1'b1;  laddr = r_free[AW-1:0];  lwd = NIL;
                        n_free = rd_lnk;  n_count = r_count + IW'(1);
                        if (r_head == NIL) begin
                            n_head = r_free;  n_state = S_RESP;
                        end else begin
                            rd_addr = r_head[AW-1:0];  n_state = S_WALK;
                        end
                    end
                    default: begin
                        rd_addr = r_head[AW-1:0];  n_state = S_WALK;
                    end
                endcase
            end
            S_WALK: begin
                unique case (r_act)
                    ACT_INS_BACK: begin
                        if (tail) begin
                            lwe = 1'b1;  lwd = r_n;  n_state = S_RESP;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    ACT_INS_AFTER: begin
                        if (hit) begin
                            lwe = 1'b1;  laddr = r_n[AW-1:0];  lwd = rd_lnk;
                            vwe = 1'b1;
                            n_free = r_nfree;  n_count = r_count + IW'(1);
                            n_wa = r_p;  n_wd = r_n;  n_state = S_WR1;
                        end else if (tail) begin
                            n_rstat = ST_NOTFOUND;  n_state = S_RESP;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    ACT_DEL_FRONT: begin
                        n_head = rd_lnk;
                        lwe = 1'b1;  lwd = r_free;
                        n_free = r_p;  n_count = r_count - IW'(1);  n_state = S_RESP;
                    end
                    ACT_DEL_BACK: begin
                        if (tail) begin
                            lwe = 1'b1;  lwd = r_free;
                            n_free = r_p;  n_count = r_count - IW'(1);
                            if (r_q == NIL) begin
                                n_head = NIL;  n_state = S_RESP;
                            end else begin
                                n_wa = r_q;  n_wd = NIL;  n_state = S_WR1;
                            end
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    ACT_DEL_KEY: begin
                        if (hit) begin
                            lwe = 1'b1;  lwd = r_free;
                            n_free = r_p;  n_count = r_count - IW'(1);
                            if (r_q == NIL) begin
                                n_head = rd_lnk;  n_state = S_RESP;
                            end else begin
                                n_wa = r_q;  n_wd = rd_lnk;  n_state = S_WR1;
                            end
                        end else if (tail) begin
                            n_rstat = ST_NOTFOUND;  n_state = S_RESP;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    ACT_FIND: begin
                        if (hit) begin
                            n_rfound = 1'b1;  n_state = S_RESP;
                        end else if (tail) begin
                            n_rstat = ST_NOTFOUND;  n_state = S_RESP;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    ACT_DUMP: begin
                        // The read address holds on the current node while the output is full.
                        if (ofree) begin
                            ld = 1'b1;  res_item = rd_val;  res_last = tail;
                            if (tail) begin
                                n_state = S_IDLE;
                            end else begin
                                adv = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
                if (adv) begin
                    n_q = r_p;  n_p = rd_lnk;  rd_addr = rd_lnk[AW-1:0];
                end
            end
            S_WR1: begin
                lwe = 1'b1;  laddr = r_wa[AW-1:0];  lwd = r_wd;  n_state = S_RESP;
            end
            S_RESP: begin
                if (ofree) begin
                    ld = 1'b1;  res_status = r_rstat;  res_found = r_rfound;  n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_free  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;  r_rstat <= n_rstat;  r_rfound <= n_rfound;
        r_value <= n_value;  r_key <= n_key;  r_nfree <= n_nfree;
        r_n <= n_n;  r_p <= n_p;  r_q <= n_q;  r_wa <= n_wa;  r_wd <= n_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ld) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_status <= res_status;  r_found <= res_found;  r_item <= res_item;
            r_last <= res_last;  r_ocount <= COUNT_W'(r_count);
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_item_value = r_item;
    assign o_last       = r_last;
    assign o_count      = r_ocount;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(CAPACITY))
        else $error("element count above capacity");

    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NIL) == (r_count == '0))
        else $error("list head disagrees with element count");

    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == NIL) == (r_count == IW'(CAPACITY)))
        else $error("free list disagrees with element count");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |-> !ld)
        else $error("result register overwritten while stalled");

endmodule

@@ test/singly_linked_list_engine_core_tb.sv @@
// Testbench for the linked list engine: directed and random requests checked against a list model.
module singly_linked_list_engine_core_tb import sll_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = CAPACITY_DEF;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] item_value;
        logic        last;
        logic [5:0]  count;
    } t_beat;

    class list_scoreboard;
        int          vals[$];
        t_beat       pending[$];
        int          mismatches;

        function void push_beat(t_status st, bit fnd, logic [31:0] iv, bit lst);
            t_beat b;
            b.status = st;
            b.found = fnd;
            b.item_value = iv;
            b.last = lst;
            b.count = 6'(vals.size());
            pending.push_back(b);
        endfunction

        function int locate(logic [31:0] k);
            foreach (vals[i]) if (vals[i] == k) return i;
            return -1;
        endfunction

        function void note_request(t_action act, logic [31:0] v, logic [31:0] k);
            int idx;
            bit full;
            bit empty;
            full = vals.size() >= CAP;
            empty = vals.size() == 0;
            case (act)
                ACT_INS_FRONT: begin
                    if (full) push_beat(ST_FULL, 0, 0, 1);
                    else begin vals.push_front(v); push_beat(ST_OK, 0, 0, 1); end
                end
                ACT_INS_BACK: begin
                    if (full) push_beat(ST_FULL, 0, 0, 1);
                    else begin vals.push_back(v); push_beat(ST_OK, 0, 0, 1); end
                end
                ACT_INS_AFTER: begin
                    idx = locate(k);
                    if (full) push_beat(ST_FULL, 0, 0, 1);
                    else if (empty) push_beat(ST_EMPTY, 0, 0, 1);
                    else if (idx < 0) push_beat(ST_NOTFOUND, 0, 0, 1);
                    else begin vals.insert(idx + 1, v); push_beat(ST_OK, 0, 0, 1); end
                end
                ACT_DEL_FRONT: begin
                    if (empty) push_beat(ST_EMPTY, 0, 0, 1);
                    else begin void'(vals.pop_front()); push_beat(ST_OK, 0, 0, 1); end
                end
                ACT_DEL_BACK: begin
                    if (empty) push_beat(ST_EMPTY, 0, 0, 1);
                    else begin void'(vals.pop_back()); push_beat(ST_OK, 0, 0, 1); end
                end
                ACT_DEL_KEY: begin
                    idx = locate(k);
                    if (empty) push_beat(ST_EMPTY, 0, 0, 1);
                    else if (idx < 0) push_beat(ST_NOTFOUND, 0, 0, 1);
                    else begin vals.delete(idx); push_beat(ST_OK, 0, 0, 1); end
                end
                ACT_FIND: begin
                    idx = locate(k);
                    if (empty) push_beat(ST_EMPTY, 0, 0, 1);
                    else if (idx < 0) push_beat(ST_NOTFOUND, 0, 0, 1);
                    else push_beat(ST_OK, 1, 0, 1);
                end
                default: begin
                    if (empty) push_beat(ST_EMPTY, 0, 0, 1);
                    else foreach (vals[i]) push_beat(ST_OK, 0, vals[i], i == vals.size() - 1);
                end
            endcase
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [2:0]  i_action = '0;
    logic signed [31:0] i_value = '0;
    logic signed [31:0] i_key = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [1:0]  o_status;
    logic        o_found;
    logic signed [31:0] o_item_value;
    logic        o_last;
    logic [5:0]  o_count;

    list_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    singly_linked_list_engine_core u_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat({o_status, o_found, o_item_value, o_last, o_count});
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Valid stays high from one beat to the next unless the sender idles in between.
    task automatic send_request(t_action act, logic [31:0] v, logic [31:0] k);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_action <= act;
        i_value <= v;
        i_key <= k;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(act, v, k);
    endtask

    // Values mostly come from small pools so that keys hit stored elements often.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7fff_fffc + $urandom_range(3);
            default: return $urandom_range(7);
        endcase
    endfunction

    task automatic random_phase(int n, int ip, int sp);
        t_action act;
        idle_pct = ip;
        stall_pct = sp;
        repeat (n) begin
            // Bias toward inserts so the list fills up at times.
            if ($urandom_range(99) < 35) act = t_action'($urandom_range(2));
            else act = t_action'($urandom_range(7));
            send_request(act, pick_value(), pick_value());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Empty-list cases, then extremes, duplicates and the full store.
        send_request(ACT_DUMP, 0, 0);
        send_request(ACT_DEL_FRONT, 0, 0);
        send_request(ACT_DEL_BACK, 0, 0);
        send_request(ACT_DEL_KEY, 0, 0);
        send_request(ACT_FIND, 0, 0);
        send_request(ACT_INS_AFTER, 1, 0);
        send_request(ACT_INS_BACK, 32'h7fff_ffff, 0);
        send_request(ACT_INS_FRONT, 32'h8000_0000, 0);
        send_request(ACT_INS_AFTER, 5, 32'h8000_0000);
        send_request(ACT_INS_AFTER, 5, 32'hffff_ffff);
        send_request(ACT_FIND, 0, 32'h7fff_ffff);
        send_request(ACT_DEL_KEY, 0, 32'h8000_0000);
        send_request(ACT_DEL_KEY, 0, 32'h1234);
        send_request(ACT_DUMP, 0, 0);
        send_request(ACT_INS_BACK, 5, 0);
        send_request(ACT_DEL_KEY, 0, 5);
        send_request(ACT_DUMP, 0, 0);
        repeat (CAP) send_request(ACT_INS_BACK, $urandom, 0);
        send_request(ACT_INS_FRONT, 1, 0);
        send_request(ACT_INS_AFTER, 1, 32'h7fff_ffff);
        send_request(ACT_DUMP, 0, 0);
        send_request(ACT_DEL_BACK, 0, 0);
        send_request(ACT_FIND, 0, 32'h7fff_ffff);
        i_in_valid <= 0;
        // Pause until every beat is out before the random part.
        while (sb.pending.size() != 0) @(posedge i_clk);
        random_phase(95, 0, 0);
        random_phase(95, 77, 0);
        random_phase(95, 0, 77);
        random_phase(95, 9, 9);
        i_in_valid <= 0;
        idle_pct = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        stall_pct = 0;
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
